// ----- rtl/core/lzap_pkg.sv -----
// Shared constants and the hash mixing function for the LZAP byte compressor.
// No dependencies.
`default_nettype none
package lzap_pkg;
   localparam int BYTE_BITS   = 8;
   localparam int IO_CODE_BITS = 16;
   localparam int LIMIT_BITS  = 16;
   localparam int KEY_BITS    = 24;
   localparam int FIRST_CODE  = 256;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd1000;
   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   // multiplicative hash, low bits of the 32-bit product select the slot
   function automatic logic [31:0] hash_mix(input logic [KEY_BITS-1:0] key);
      logic [31:0] prod;
      prod = 32'(key) * HASH_MULT;
      return prod;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/core/lzap_dict_mem.sv -----
// Dictionary slot memory: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none
module lzap_dict_mem #(
   parameter int ADDR_BITS  = 13,
   parameter int ENTRY_BITS = 33
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_BITS-1:0]  wr_addr,
   input  wire logic [ENTRY_BITS-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_BITS-1:0]  rd_addr,
   output logic      [ENTRY_BITS-1:0] rd_data
);
   logic [ENTRY_BITS-1:0] mem_ff [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/lzap_ctrl.sv -----
// Sequencer: hashing, linear probing, insert and extension of dictionary entries.
// Depends on lzap_pkg; drives the ports of lzap_dict_mem.
`default_nettype none
module lzap_ctrl #(
   parameter int CODE_BITS  = 12,
   parameter int ADDR_BITS  = 13,
   parameter int MAX_PROBES = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [lzap_pkg::BYTE_BITS-1:0]        req_byte,
   input  wire logic                                  req_last,
   input  wire logic [lzap_pkg::LIMIT_BITS-1:0]       extend_limit,
   output logic                                       emit_valid,
   input  wire logic                                  emit_ready,
   output logic      [CODE_BITS-1:0]                  emit_code,
   output logic                                       emit_last,
   output logic                                       mem_wr_en,
   output logic      [ADDR_BITS-1:0]                  mem_wr_addr,
   output logic      [2*CODE_BITS+lzap_pkg::BYTE_BITS:0] mem_wr_data,
   output logic                                       mem_rd_en,
   output logic      [ADDR_BITS-1:0]                  mem_rd_addr,
   input  wire logic [2*CODE_BITS+lzap_pkg::BYTE_BITS:0] mem_rd_data
);
   import lzap_pkg::*;

   localparam int ENTRY_BITS = 2*CODE_BITS + BYTE_BITS + 1;
   localparam int PCNT_BITS  = $clog2(MAX_PROBES + 1);
   localparam logic [CODE_BITS-1:0] SENTINEL  = {CODE_BITS{1'b1}};
   localparam logic [CODE_BITS-1:0] CODE_INIT = CODE_BITS'(FIRST_CODE);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_RD, ST_CHK,
      ST_EMIT_MISS, ST_FINISH, ST_EMIT_LAST
   } state_type;

   state_type               state_ff;
   logic [ADDR_BITS-1:0]    clr_addr_ff;
   logic [BYTE_BITS-1:0]    byte_ff;
   logic                    last_ff;
   logic [CODE_BITS-1:0]    match_ff;
   logic                    match_valid_ff;
   logic [CODE_BITS-1:0]    ext_code_ff;
   logic [LIMIT_BITS-1:0]   ext_cnt_ff;
   logic [CODE_BITS-1:0]    next_code_ff;
   logic [CODE_BITS-1:0]    key_prefix_ff;
   logic [CODE_BITS-1:0]    put_code_ff;
   logic [CODE_BITS-1:0]    hit_code_ff;
   logic [ADDR_BITS-1:0]    probe_addr_ff;
   logic [PCNT_BITS-1:0]    probe_cnt_ff;
   logic                    is_put_ff;
   logic                    is_ext_ff;

   logic                    e_valid;
   logic [CODE_BITS-1:0]    e_prefix;
   logic [BYTE_BITS-1:0]    e_byte;
   logic [CODE_BITS-1:0]    e_code;
   logic                    e_hit;
   logic                    probe_last;
   logic [31:0]             hash_val;
   logic [CODE_BITS-1:0]    put_result;

   assign e_valid    = mem_rd_data[ENTRY_BITS-1];
   assign e_prefix   = mem_rd_data[ENTRY_BITS-2 -: CODE_BITS];
   assign e_byte     = mem_rd_data[CODE_BITS +: BYTE_BITS];
   assign e_code     = mem_rd_data[CODE_BITS-1:0];
   assign e_hit      = e_valid && (e_prefix == key_prefix_ff) && (e_byte == byte_ff);
   assign probe_last = probe_cnt_ff == PCNT_BITS'(MAX_PROBES - 1);
   assign hash_val   = hash_mix(KEY_BITS'({key_prefix_ff, byte_ff}));
   assign put_result = e_hit ? e_code : put_code_ff;

   assign req_tready  = state_ff == ST_IDLE;
   assign emit_valid  = (state_ff == ST_EMIT_MISS) || (state_ff == ST_EMIT_LAST);
   assign emit_code   = match_ff;
   assign emit_last   = state_ff == ST_EMIT_LAST;
   assign mem_rd_en   = state_ff == ST_RD;
   assign mem_rd_addr = probe_addr_ff;
   assign mem_wr_en   = (state_ff == ST_CLEAR) ||
                        ((state_ff == ST_CHK) && is_put_ff && !e_valid);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : probe_addr_ff;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0
                        : {1'b1, key_prefix_ff, byte_ff, put_code_ff};

   always_ff @(posedge clock) begin
      if (reset || (state_ff == ST_EMIT_LAST && emit_ready)) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         match_ff       <= '0;
         match_valid_ff <= 1'b0;
         ext_code_ff    <= '0;
         ext_cnt_ff     <= '0;
         next_code_ff   <= CODE_INIT;
         is_put_ff      <= 1'b0;
         is_ext_ff      <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (&clr_addr_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  byte_ff <= req_byte;
                  last_ff <= req_last;
                  if (!match_valid_ff) begin
                     match_ff       <= CODE_BITS'(req_byte);
                     match_valid_ff <= 1'b1;
                     state_ff       <= ST_FINISH;
                  end else begin
                     key_prefix_ff <= match_ff;
                     is_put_ff     <= 1'b0;
                     state_ff      <= ST_HASH;
                  end
               end
            end
            ST_HASH: begin
               probe_addr_ff <= hash_val[ADDR_BITS-1:0];
               probe_cnt_ff  <= '0;
               state_ff      <= ST_RD;
            end
            ST_RD: begin
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               if (!is_put_ff) begin
                  if (e_hit) begin
                     if (ext_cnt_ff > LIMIT_BITS'(1)) begin
                        if (next_code_ff < SENTINEL) begin
                           key_prefix_ff <= ext_code_ff;
                           put_code_ff   <= next_code_ff;
                           hit_code_ff   <= e_code;
                           is_put_ff     <= 1'b1;
                           is_ext_ff     <= 1'b1;
                           state_ff      <= ST_HASH;
                        end else begin
                           ext_cnt_ff <= ext_cnt_ff - 1'b1;
                           match_ff   <= e_code;
                           state_ff   <= ST_FINISH;
                        end
                     end else begin
                        match_ff <= e_code;
                        state_ff <= ST_FINISH;
                     end
                  end else if (!e_valid || probe_last) begin
                     state_ff <= ST_EMIT_MISS;
                  end else begin
                     probe_addr_ff <= probe_addr_ff + 1'b1;
                     probe_cnt_ff  <= probe_cnt_ff + 1'b1;
                     state_ff      <= ST_RD;
                  end
               end else begin
                  if (!e_valid || e_hit || probe_last) begin
                     // insert finished (stored, duplicate, or window full)
                     next_code_ff <= next_code_ff + 1'b1;
                     if (is_ext_ff) begin
                        ext_code_ff <= e_valid ? put_result : put_code_ff;
                        ext_cnt_ff  <= ext_cnt_ff - 1'b1;
                        match_ff    <= hit_code_ff;
                     end else begin
                        ext_code_ff <= put_code_ff;
                        ext_cnt_ff  <= extend_limit;
                        match_ff    <= CODE_BITS'(byte_ff);
                     end
                     state_ff <= ST_FINISH;
                  end else begin
                     probe_addr_ff <= probe_addr_ff + 1'b1;
                     probe_cnt_ff  <= probe_cnt_ff + 1'b1;
                     state_ff      <= ST_RD;
                  end
               end
            end
            ST_EMIT_MISS: begin
               if (emit_ready) begin
                  if (next_code_ff != SENTINEL) begin
                     put_code_ff <= next_code_ff;
                     is_put_ff   <= 1'b1;
                     is_ext_ff   <= 1'b0;
                     state_ff    <= ST_HASH;
                  end else begin
                     match_ff <= CODE_BITS'(byte_ff);
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               state_ff <= last_ff ? ST_EMIT_LAST : ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/lzap_byte_compressor_top.sv -----
// LZAP byte compressor. One byte per transfer; the first byte of a stream only starts the match,
// a later byte is looked up by probing up to MAX_PROBES slots, each probe a slot read with
// registered read data. A miss passes its code on, then inserts while codes remain, and a hit
// may insert an extension; the final byte adds its last code; output stalls hold the flow.
// Reset and every end of stream start a clearing pass over all TABLE_DEPTH slots, no byte taken;
// extend_limit resets to 1000. Needs lzap_pkg, lzap_ctrl, lzap_dict_mem; depth a power of 2.
`default_nettype none
module lzap_byte_compressor_top #(
   parameter int CODE_BITS   = 12,
   parameter int TABLE_DEPTH = 8192,
   parameter int MAX_PROBES  = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [15:0] code
   output logic             rsp_tlast,   // last_code
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // extend_limit
);
   import lzap_pkg::*;

   localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
   localparam int ENTRY_BITS = 2*CODE_BITS + BYTE_BITS + 1;

   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  out_valid_ff;
   logic [CODE_BITS-1:0]  out_code_ff;
   logic                  out_last_ff;

   logic                  emit_valid;
   logic                  emit_ready;
   logic [CODE_BITS-1:0]  emit_code;
   logic                  emit_last;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;

   assign csr_ready  = 1'b1;
   assign emit_ready = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = IO_CODE_BITS'(out_code_ff);
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit_ready) begin
         out_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_ready && emit_valid) begin
         out_code_ff <= emit_code;
         out_last_ff <= emit_last;
      end
   end

   lzap_ctrl #(
      .CODE_BITS  (CODE_BITS),
      .ADDR_BITS  (ADDR_BITS),
      .MAX_PROBES (MAX_PROBES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_byte     (req_tdata),
      .req_last     (req_tlast),
      .extend_limit (limit_ff),
      .emit_valid   (emit_valid),
      .emit_ready   (emit_ready),
      .emit_code    (emit_code),
      .emit_last    (emit_last),
      .mem_wr_en    (wr_en),
      .mem_wr_addr  (wr_addr),
      .mem_wr_data  (wr_data),
      .mem_rd_en    (rd_en),
      .mem_rd_addr  (rd_addr),
      .mem_rd_data  (rd_data)
   );

   lzap_dict_mem #(
      .ADDR_BITS  (ADDR_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_dict_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
endmodule
`default_nettype wire
